@@ design/wam_pkg.sv @@
// Shared types and constants for the window average / min / max block.
`timescale 1ns / 1ps
`default_nettype none
package wam_pkg;
   localparam int Depth     = 1024;
   localparam int AddrWidth = $clog2(Depth);
   localparam int LenWidth  = 11;
   localparam int SampWidth = 16;
   localparam int SumWidth  = 26;
   localparam int CntWidth  = $clog2(SumWidth + 1);
   localparam int Lanes     = 3;

   typedef logic signed [SampWidth-1:0] sample_type;
   typedef logic [AddrWidth-1:0]        addr_type;
   typedef logic [LenWidth-1:0]         len_type;
   typedef logic signed [SumWidth-1:0]  sum_type;

   // control shared by all lanes
   typedef struct packed {
      logic     wr_en;
      addr_type wr_addr;
      addr_type rd_addr;
      logic     sum_clr;
      logic     sum_upd;
      logic     sub_old;
      logic     scan_vld;
      logic     scan_first;
      logic     div_start;
      len_type  len;
   } lane_ctrl_type;

   typedef struct packed {
      sample_type mean;
      sample_type hi;
      sample_type lo;
      logic       done;
   } lane_res_type;
endpackage
`default_nettype wire

@@ design/wam_if.sv @@
// Item channel interfaces: sample input and statistics result.
`timescale 1ns / 1ps
`default_nettype none
interface wam_req_if;
   logic                valid;
   logic                ready;
   wam_pkg::sample_type gyro_x;
   wam_pkg::sample_type gyro_y;
   wam_pkg::sample_type gyro_z;
   modport source (output valid, gyro_x, gyro_y, gyro_z, input ready);
   modport sink (input valid, gyro_x, gyro_y, gyro_z, output ready);
endinterface

interface wam_rsp_if;
   logic                valid;
   logic                ready;
   wam_pkg::sample_type echo_x;
   wam_pkg::sample_type echo_y;
   wam_pkg::sample_type echo_z;
   wam_pkg::sample_type mean_x;
   wam_pkg::sample_type mean_y;
   wam_pkg::sample_type mean_z;
   wam_pkg::sample_type max_x;
   wam_pkg::sample_type min_x;
   wam_pkg::sample_type max_y;
   wam_pkg::sample_type min_y;
   wam_pkg::sample_type max_z;
   wam_pkg::sample_type min_z;
   modport source (output valid, echo_x, echo_y, echo_z, mean_x, mean_y, mean_z,
                   max_x, min_x, max_y, min_y, max_z, min_z, input ready);
   modport sink (input valid, echo_x, echo_y, echo_z, mean_x, mean_y, mean_z,
                 max_x, min_x, max_y, min_y, max_z, min_z, output ready);
endinterface
`default_nettype wire

@@ design/wam_div.sv @@
// Signed-by-unsigned restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module wam_div (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire wam_pkg::sum_type dividend,
   input  wire wam_pkg::len_type divisor,
   output logic                  done,
   output wam_pkg::sample_type   quotient
);
   import wam_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                neg_ff, neg_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic [SumWidth-1:0] quo_ff, quo_in;
   logic [LenWidth-1:0] rem_ff, rem_in;
   logic [LenWidth:0]   trial;
   logic [SumWidth-1:0] quo_neg;

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, quo_ff[SumWidth-1]};
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         neg_in  = dividend[SumWidth-1];
         cnt_in  = '0;
         quo_in  = dividend[SumWidth-1] ? SumWidth'(-dividend) : SumWidth'(dividend);
         rem_in  = '0;
      end else if (busy_ff) begin
         quo_in = {quo_ff[SumWidth-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in    = LenWidth'(trial - {1'b0, divisor});
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial[LenWidth-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CntWidth'(SumWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quo_neg  = -quo_ff;
   assign done     = done_ff;
   assign quotient = neg_ff ? quo_neg[SampWidth-1:0] : quo_ff[SampWidth-1:0];
endmodule
`default_nettype wire

@@ design/wam_lane.sv @@
// One axis lane: window memory, running sum, min/max scan and mean divider.
`timescale 1ns / 1ps
`default_nettype none
module wam_lane (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire wam_pkg::lane_ctrl_type ctrl,
   input  wire wam_pkg::sample_type    sample,
   output wam_pkg::lane_res_type       res
);
   import wam_pkg::*;

   logic [SampWidth-1:0] mem [Depth];
   sample_type           rdata_ff;
   sum_type              sum_ff, sum_in;
   sample_type           hi_ff, hi_in;
   sample_type           lo_ff, lo_in;
   sample_type           quo;
   logic                 div_done;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= sample;
      end
      rdata_ff <= sample_type'(mem[ctrl.rd_addr]);
   end

   always_comb begin
      sum_in = sum_ff;
      if (ctrl.sum_clr) begin
         sum_in = '0;
      end else if (ctrl.sum_upd) begin
         sum_in = sum_ff + SumWidth'(sample)
                  - (ctrl.sub_old ? SumWidth'(rdata_ff) : SumWidth'(0));
      end
      hi_in = hi_ff;
      lo_in = lo_ff;
      if (ctrl.scan_vld) begin
         if (ctrl.scan_first || rdata_ff > hi_ff) hi_in = rdata_ff;
         if (ctrl.scan_first || rdata_ff < lo_ff) lo_in = rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   wam_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.div_start),
      .dividend (sum_ff),
      .divisor  (ctrl.len),
      .done     (div_done),
      .quotient (quo)
   );

   assign res = '{mean: quo, hi: hi_ff, lo: lo_ff, done: div_done};
endmodule
`default_nettype wire

@@ design/window_average_min_max.sv @@
// Top level: sliding-window mean, max and min over a three-axis gyro stream.
// req_chan takes one item per sample (gyro_x/y/z, signed Q8.8); rsp_chan gives
// one item with the echoed sample and per-axis mean (truncated toward zero),
// max and min. An item moves on a clock edge with valid and ready high.
// csr_wr_en/csr_wr_data write window_length (0 acts as 1, above 1024 acts as
// 1024); a write restarts filling. No result is given for the first L + 1
// samples taken since reset or the last length write.
// Three lanes (one per axis) each hold a 1024 x 16 window RAM, a running sum,
// a min/max scanner and a serial divider; the output register merges them.
// From acceptance: S_READ reads the oldest entry, S_UPDATE writes the sample
// and updates the sum, then S_SCAN issues L scan reads through the one RAM
// read port while the divide runs; S_WAIT holds until every divider is done
// and the output register is free. An item without a result goes idle after
// S_UPDATE. rsp_chan.valid rises with req_chan.ready. One item at a time.
// Reset clears pointer, sample count, sums and output valid; window RAM is
// not cleared, and its contents are never used before being written.
// When the receiver stalls, the result waits in the output register and the
// next sample is still taken; its result waits until the register is free.
`timescale 1ns / 1ps
`default_nettype none
module window_average_min_max (
   input  wire logic              clock,
   input  wire logic              reset,
   wam_req_if.sink                req_chan,
   wam_rsp_if.source              rsp_chan,
   input  wire logic              csr_wr_en,
   input  wire wam_pkg::len_type  csr_wr_data
);
   import wam_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_READ   = 5'b00010,
      S_UPDATE = 5'b00100,
      S_SCAN   = 5'b01000,
      S_WAIT   = 5'b10000
   } state_type;

   state_type     state_ff, state_in;
   len_type       wlen_ff;
   len_type       len;
   addr_type      wp_ff, wp_in;
   len_type       seen_ff, seen_in;
   addr_type      newest_ff, oldest_ff;
   logic          full_ff, emit_ff;
   sample_type    samp_ff [Lanes];
   addr_type      cnt_ff, cnt_in;
   logic          issue_ff, first_ff;
   logic          last_issue;
   lane_ctrl_type ctrl;
   lane_res_type  res [Lanes];
   logic          div_all_done;
   logic          out_free;
   logic          accept;
   logic          load;
   logic          rsp_valid_ff;
   sample_type    echo_ff [Lanes];
   sample_type    mean_ff [Lanes];
   sample_type    hi_ff [Lanes];
   sample_type    lo_ff [Lanes];

   // effective window length
   always_comb begin
      if (wlen_ff == '0) len = LenWidth'(1);
      else if (wlen_ff > LenWidth'(Depth)) len = LenWidth'(Depth);
      else len = wlen_ff;
   end

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign last_issue     = (cnt_ff == AddrWidth'(len - 1'b1));
   assign div_all_done   = res[0].done && res[1].done && res[2].done;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign load           = (state_ff == S_WAIT) && !issue_ff && div_all_done && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff <= LenWidth'(1);
      end else if (csr_wr_en) begin
         wlen_ff <= csr_wr_data;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      wp_in    = wp_ff;
      seen_in  = seen_ff;
      cnt_in   = cnt_ff;
      ctrl     = '0;
      ctrl.len = len;
      ctrl.wr_addr = newest_ff;
      ctrl.rd_addr = oldest_ff;
      ctrl.sum_clr    = csr_wr_en;
      ctrl.scan_vld   = issue_ff;
      ctrl.scan_first = first_ff;
      if (csr_wr_en) seen_in = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_READ;
         end
         S_READ: begin
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            ctrl.wr_en   = 1'b1;
            ctrl.sum_upd = 1'b1;
            ctrl.sub_old = full_ff;
            wp_in        = newest_ff + 1'b1;
            seen_in      = (seen_ff < len + 1'b1) ? seen_ff + 1'b1 : len + 1'b1;
            cnt_in       = '0;
            state_in     = emit_ff ? S_SCAN : S_IDLE;
         end
         S_SCAN: begin
            ctrl.rd_addr   = newest_ff - cnt_ff;
            ctrl.div_start = (cnt_ff == '0);
            cnt_in         = cnt_ff + 1'b1;
            if (last_issue) state_in = S_WAIT;
         end
         S_WAIT: begin
            if (load) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         wp_ff    <= '0;
         seen_ff  <= '0;
         issue_ff <= 1'b0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
         seen_ff  <= seen_in;
         issue_ff <= (state_ff == S_SCAN);
         first_ff <= (state_ff == S_SCAN) && (cnt_ff == '0);
      end
      cnt_ff <= cnt_in;
      if (accept) begin
         newest_ff  <= wp_ff;
         oldest_ff  <= wp_ff - AddrWidth'(len);   // wraps; full depth lands on newest
         full_ff    <= (seen_ff >= len);
         emit_ff    <= (seen_ff > len);
         samp_ff[0] <= req_chan.gyro_x;
         samp_ff[1] <= req_chan.gyro_y;
         samp_ff[2] <= req_chan.gyro_z;
      end
   end

   // one lane per axis
   for (genvar g = 0; g < Lanes; g++) begin : g_lane
      wam_lane u_lane (
         .clock  (clock),
         .reset  (reset),
         .ctrl   (ctrl),
         .sample (samp_ff[g]),
         .res    (res[g])
      );
   end

   // merge stage / output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load) begin
         for (int i = 0; i < Lanes; i++) begin
            echo_ff[i] <= samp_ff[i];
            mean_ff[i] <= res[i].mean;
            hi_ff[i]   <= res[i].hi;
            lo_ff[i]   <= res[i].lo;
         end
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.echo_x = echo_ff[0];
   assign rsp_chan.echo_y = echo_ff[1];
   assign rsp_chan.echo_z = echo_ff[2];
   assign rsp_chan.mean_x = mean_ff[0];
   assign rsp_chan.mean_y = mean_ff[1];
   assign rsp_chan.mean_z = mean_ff[2];
   assign rsp_chan.max_x  = hi_ff[0];
   assign rsp_chan.min_x  = lo_ff[0];
   assign rsp_chan.max_y  = hi_ff[1];
   assign rsp_chan.min_y  = lo_ff[1];
   assign rsp_chan.max_z  = hi_ff[2];
   assign rsp_chan.min_z  = lo_ff[2];

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_READ)
      else $error("accepted item did not start the old-entry read");
   a_seen_sat: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= len + 1'b1)
      else $error("sample count above window plus one");
   a_scan_data: assert property (@(posedge clock) disable iff (reset)
      issue_ff |-> state_ff == S_SCAN || state_ff == S_WAIT)
      else $error("scan data outside scan");
   a_load_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_WAIT))
      else $error("result loaded outside wait state");
endmodule
`default_nettype wire
